FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the top-level RTL file.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold on every clock edge once the reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same kind of check, but the condition must never hold.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/s2da_pkg.sv
// ----------------------------------------------------------------------------
// s2da_pkg
// Shared types, constants and helpers for the signed integer to decimal text
// converter.
// ----------------------------------------------------------------------------
package s2da_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] digit_t;

  localparam char_t  CHAR_ZERO        = 8'd48;
  localparam char_t  CHAR_MINUS       = 8'd45;
  localparam digit_t DIGIT_MAX        = 4'd9;
  localparam int     DIGIT_BITS       = 4;
  localparam int     BITS_PER_STAGE   = 4;
  localparam digit_t ADJUST_THRESHOLD = 4'd5;
  localparam digit_t ADJUST_OFFSET    = 4'd3;

  // Double dabble correction applied to a BCD digit before each shift.
  function automatic digit_t dabble_adjust(input digit_t d);
    return (d >= ADJUST_THRESHOLD) ? digit_t'(d + ADJUST_OFFSET) : d;
  endfunction

endpackage

FILE: src/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed two's complement integer into its decimal ASCII text.
//
// Usage: a number is transferred on the input channel (in_valid_i,
// in_ready_o, number_i). Its text leaves on the output channel (out_valid_o,
// out_ready_i) one character per transfer, most significant first: a minus
// sign for negative values, then the digits without leading zeros. Zero
// gives the single character '0'. is_last_o marks the final character.
// One register forms the sign and magnitude, then ceil(VALUE_WIDTH/4)
// double dabble stages follow (8 at 32 bits), then the character generator
// loads the digits and drives the output register. The conversion pipeline
// takes a new number every cycle while the stages after it accept; the
// character generator loads the next number only once the final character
// of the previous one has entered the output register.
// When the receiver stalls, the output holds its character, the generator
// waits and the conversion stages fill and then stall in place without loss.
// Reset empties every stage, the generator's busy flag and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] number_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output s2da_pkg::char_t        text_char_o,
  output logic                   is_last_o
);
  import s2da_pkg::*;

  // Stage count and padded magnitude width for four bits per stage.
  localparam int NumStages = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int PadWidth  = NumStages * BITS_PER_STAGE;
  // Decimal digits of the largest magnitude 2^(VALUE_WIDTH-1).
  localparam int NumDigits = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BcdWidth  = NumDigits * DIGIT_BITS;

  // Input stage: sign and unsigned magnitude. The most negative value
  // negates to itself, which read as unsigned is the exact magnitude.
  logic                   in_stage_valid_q;
  logic                   in_stage_neg_q;
  logic [VALUE_WIDTH-1:0] in_stage_mag_q;
  logic                   number_neg;
  logic [VALUE_WIDTH-1:0] number_mag;

  // Chain between the conversion stages; entry 0 is the input stage.
  logic [NumStages:0]  chain_valid;
  logic [NumStages:0]  chain_ready;
  logic [NumStages:0]  chain_neg;
  logic [PadWidth-1:0] chain_bin [NumStages+1];
  logic [BcdWidth-1:0] chain_bcd [NumStages+1];

  // Character classes seen on the output, used by the checks below.
  logic                   out_is_minus;
  logic                   out_is_digit;

  assign number_neg = number_i[VALUE_WIDTH-1];
  assign number_mag = number_neg ? VALUE_WIDTH'(-number_i) : VALUE_WIDTH'(number_i);

  assign in_ready_o = !in_stage_valid_q || chain_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_stage_neg_q <= number_neg;
      in_stage_mag_q <= number_mag;
    end
  end

  assign chain_valid[0] = in_stage_valid_q;
  assign chain_neg[0]   = in_stage_neg_q;
  assign chain_bin[0]   = PadWidth'(in_stage_mag_q);
  assign chain_bcd[0]   = '0;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    s2da_dabble_stage #(
      .PadWidth  (PadWidth),
      .NumDigits (NumDigits)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[s]),
      .in_ready_o  (chain_ready[s]),
      .in_neg_i    (chain_neg[s]),
      .in_bin_i    (chain_bin[s]),
      .in_bcd_i    (chain_bcd[s]),
      .out_valid_o (chain_valid[s+1]),
      .out_ready_i (chain_ready[s+1]),
      .out_neg_o   (chain_neg[s+1]),
      .out_bin_o   (chain_bin[s+1]),
      .out_bcd_o   (chain_bcd[s+1])
    );
  end

  // The fully shifted magnitude is no longer needed past the last stage;
  // the digits alone carry the value from here on.
  s2da_emitter #(
    .NumDigits (NumDigits)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[NumStages]),
    .in_ready_o  (chain_ready[NumStages]),
    .in_neg_i    (chain_neg[NumStages]),
    .in_bcd_i    (chain_bcd[NumStages]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .is_last_o   (is_last_o)
  );

  assign out_is_minus = (text_char_o == CHAR_MINUS);
  assign out_is_digit = (text_char_o >= CHAR_ZERO) &&
                        (text_char_o <= CHAR_ZERO + char_t'(DIGIT_MAX));

  // A minus sign always has digits after it.
  `ASSERT_NEVER(a_minus_not_last, out_valid_o && out_is_minus && is_last_o, "minus sign is last")

  // Only a minus sign or a decimal digit is ever presented.
  `ASSERT_CLK(a_char_legal, out_valid_o |-> out_is_minus || out_is_digit, "illegal character")

  // Characters of one number follow each other without a gap.
  `ASSERT_CLK(a_no_gap_in_text, out_valid_o && out_ready_i && !is_last_o |=> out_valid_o, "text gap")

endmodule

FILE: src/s2da_dabble_stage.sv
// ----------------------------------------------------------------------------
// s2da_dabble_stage
// One pipeline stage of the binary to BCD conversion; it shifts a fixed
// number of magnitude bits into the BCD digits.
// ----------------------------------------------------------------------------
module s2da_dabble_stage #(
  parameter int PadWidth  = 32,
  parameter int NumDigits = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_neg_i,
  input  logic [PadWidth-1:0]               in_bin_i,
  input  logic [NumDigits*s2da_pkg::DIGIT_BITS-1:0] in_bcd_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_neg_o,
  output logic [PadWidth-1:0]               out_bin_o,
  output logic [NumDigits*s2da_pkg::DIGIT_BITS-1:0] out_bcd_o
);
  import s2da_pkg::*;

  localparam int BcdWidth = NumDigits * DIGIT_BITS;

  logic                valid_q;
  logic                neg_q;
  logic [PadWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0] bcd_q, bcd_d;

  // Each step adjusts every digit, then shifts the next magnitude bit in.
  always_comb begin
    logic [PadWidth-1:0] bin;
    logic [BcdWidth-1:0] bcd;
    bin = in_bin_i;
    bcd = in_bcd_i;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        bcd[d*DIGIT_BITS +: DIGIT_BITS] = dabble_adjust(bcd[d*DIGIT_BITS +: DIGIT_BITS]);
      end
      bcd = {bcd[BcdWidth-2:0], bin[PadWidth-1]};
      bin = {bin[PadWidth-2:0], 1'b0};
    end
    bin_d = bin;
    bcd_d = bcd;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      neg_q <= in_neg_i;
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_neg_o   = neg_q;
  assign out_bin_o   = bin_q;
  assign out_bcd_o   = bcd_q;

endmodule

FILE: src/s2da_emitter.sv
// ----------------------------------------------------------------------------
// s2da_emitter
// Holds one converted value and sends its characters one per cycle, while the
// receiver accepts them, through an output register, sign first, leading zeros skipped.
// ----------------------------------------------------------------------------
module s2da_emitter #(
  parameter int NumDigits = 10
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic                                      in_neg_i,
  input  logic [NumDigits*s2da_pkg::DIGIT_BITS-1:0] in_bcd_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output s2da_pkg::char_t                           text_char_o,
  output logic                                      is_last_o
);
  import s2da_pkg::*;

  localparam int IdxWidth = $clog2(NumDigits);

  logic                busy_q;
  logic                sign_q;
  logic [IdxWidth-1:0] idx_q, idx_d;
  digit_t              dig_q [NumDigits];
  logic                out_valid_q;
  char_t               char_q;
  logic                last_q;
  logic [IdxWidth-1:0] top_idx;
  logic                load, advance;

  // Highest nonzero digit; zero prints as a single digit.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (in_bcd_i[i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
        top_idx = IdxWidth'(i);
      end
    end
  end

  assign in_ready_o = !busy_q;
  assign load       = in_valid_i && !busy_q;
  assign advance    = busy_q && (!out_valid_q || out_ready_i);
  assign idx_d      = idx_q - IdxWidth'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (advance && !sign_q && idx_q == '0) begin
        busy_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sign_q <= in_neg_i;
      idx_q  <= top_idx;
      for (int i = 0; i < NumDigits; i++) begin
        dig_q[i] <= in_bcd_i[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end else if (advance) begin
      if (sign_q) begin
        sign_q <= 1'b0;
        char_q <= CHAR_MINUS;
        last_q <= 1'b0;
      end else begin
        idx_q  <= idx_d;
        char_q <= CHAR_ZERO + char_t'(dig_q[idx_q]);
        last_q <= (idx_q == '0);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign is_last_o   = last_q;

endmodule
